// File: design/rfow_pkg.sv
// Shared types and constants for the ring FIFO with overwrite and watermark.
`timescale 1ns / 1ps
`default_nettype none

package rfow_pkg;

  localparam int OP_W       = 2;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 5;
  localparam int OVF_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_LEN_W  = 5;

  localparam logic [CFG_LEN_W-1:0] CFG_LEN_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [OVF_W-1:0] {
    OVF_NONE   = 2'd0,
    OVF_DROP   = 2'd1,
    OVF_REJECT = 2'd2
  } ovf_t;

  localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 1'b1;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic               pop_valid;
    logic [VALUE_W-1:0] pop_value;
    ovf_t               overflow_status;
    logic [COUNT_W-1:0] fill_count;
    logic [COUNT_W-1:0] high_water;
  } rsp_t;

  typedef struct packed {
    logic               pop_valid;
    ovf_t               overflow_status;
    logic [COUNT_W-1:0] fill_count;
    logic [COUNT_W-1:0] high_water;
  } status_t;

endpackage

`default_nettype wire

// File: design/rfow_mem.sv
// Slot memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rfow_mem #(
  parameter int DEPTH     = 16,
  parameter int ELEM_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [ELEM_BITS-1:0]     wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [ELEM_BITS-1:0]     rdata
);

  logic [ELEM_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/rfow_ctrl.sv
// Pointer, count and watermark update, configuration registers and memory requests.
`timescale 1ns / 1ps
`default_nettype none

module rfow_ctrl import rfow_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int ELEM_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire cmd_t                     cmd,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  output logic                          mem_we,
  output logic      [$clog2(DEPTH)-1:0] mem_waddr,
  output logic      [ELEM_BITS-1:0]     mem_wdata,
  output logic                          mem_re,
  output logic      [$clog2(DEPTH)-1:0] mem_raddr,
  output status_t                       status
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ADV_W = IDX_W + 1;
  localparam int LW    = (CNT_W > CFG_LEN_W) ? CNT_W : CFG_LEN_W;

  logic                 overwrite_when_full;
  logic [CFG_LEN_W-1:0] length_in_use;
  logic [IDX_W-1:0]     read_index;
  logic [IDX_W-1:0]     read_index_next;
  logic [IDX_W-1:0]     write_index;
  logic [IDX_W-1:0]     write_index_next;
  logic [CNT_W-1:0]     held_count;
  logic [CNT_W-1:0]     held_count_next;
  logic [CNT_W-1:0]     peak_count;
  logic [CNT_W-1:0]     peak_count_next;
  logic [LW-1:0]        len_raw;
  logic [CNT_W-1:0]     len;
  logic                 full;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] n);
    logic [ADV_W-1:0] nx;
    nx = {1'b0, idx} + ADV_W'(1);
    return (nx >= ADV_W'(n)) ? '0 : nx[IDX_W-1:0];
  endfunction

  always_comb begin
    len_raw = LW'(length_in_use);
    if (len_raw == '0) begin
      len = CNT_W'(1);
    end else if (len_raw > LW'(DEPTH)) begin
      len = CNT_W'(DEPTH);
    end else begin
      len = CNT_W'(len_raw);
    end
  end

  assign full = held_count >= len;

  always_comb begin
    read_index_next  = read_index;
    write_index_next = write_index;
    held_count_next  = held_count;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_waddr        = write_index;
    mem_raddr        = read_index;
    mem_wdata        = ELEM_BITS'(cmd.push_value);
    status           = '0;
    status.overflow_status = OVF_NONE;
    if (accept) begin
      case (cmd.op)
        OP_PUSH: begin
          if (full && !overwrite_when_full) begin
            status.overflow_status = OVF_REJECT;
          end else begin
            if (full) begin
              read_index_next        = advance(read_index, len);
              status.overflow_status = OVF_DROP;
            end else begin
              held_count_next = held_count + CNT_W'(1);
            end
            mem_we           = 1'b1;
            write_index_next = advance(write_index, len);
          end
        end
        OP_POP: begin
          if (held_count != '0) begin
            mem_re           = 1'b1;
            status.pop_valid = 1'b1;
            read_index_next  = advance(read_index, len);
            held_count_next  = held_count - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          read_index_next  = '0;
          write_index_next = '0;
          held_count_next  = '0;
        end
        default: begin
        end
      endcase
    end
    peak_count_next   = (held_count_next > peak_count) ? held_count_next : peak_count;
    status.fill_count = COUNT_W'(held_count_next);
    status.high_water = COUNT_W'(peak_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index  <= '0;
      write_index <= '0;
      held_count  <= '0;
      peak_count  <= '0;
    end else begin
      read_index  <= read_index_next;
      write_index <= write_index_next;
      held_count  <= held_count_next;
      peak_count  <= peak_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overwrite_when_full <= 1'b0;
      length_in_use       <= CFG_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OVERWRITE: overwrite_when_full <= cfg_data[0];
        REG_LENGTH:    length_in_use       <= cfg_data[CFG_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/rfow_out.sv
// Read-data stage and output register that join memory data with the step status.
`timescale 1ns / 1ps
`default_nettype none

module rfow_out import rfow_pkg::*; #(
  parameter int ELEM_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire status_t              status,
  input  wire logic [ELEM_BITS-1:0] rdata,
  output logic                      can_take,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output rsp_t                      rsp
);

  logic    s1_valid;
  status_t s1_status;
  logic    s1_move;

  assign s1_move  = s1_valid && (!rsp_valid || rsp_ready);
  assign can_take = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_status <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.pop_valid       <= s1_status.pop_valid;
      rsp.pop_value       <= s1_status.pop_valid ? VALUE_W'(rdata) : '0;
      rsp.overflow_status <= s1_status.overflow_status;
      rsp.fill_count      <= s1_status.fill_count;
      rsp.high_water      <= s1_status.high_water;
    end
  end

endmodule

`default_nettype wire

// File: design/ring_fifo_overwrite_watermark_unit.sv
// Top level of the ring FIFO with overwrite mode and high-water mark.
//
//   Channel  Signals                          Direction  Contents
//   cmd      cmd_valid / cmd_ready / cmd      in         op and push_value per transaction
//   rsp      rsp_valid / rsp_ready / rsp      out        one result per command transaction
//   cfg      cfg_we / cfg_index / cfg_data    in         register writes, no handshake back
//
// One command is taken per clock cycle while cmd_ready is high. The registered read port
// of the slot memory and the read stage load at the acceptance edge; the output register
// loads from the read stage when it is empty or its result is taken. Pointers and counts
// update at acceptance, so commands that follow back to back see each other without
// forwarding. A stalled result holds the output register; once the read stage is also
// occupied, cmd_ready drops. Reset does not clear the slot contents.
`timescale 1ns / 1ps
`default_nettype none

module ring_fifo_overwrite_watermark_unit import rfow_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int ELEM_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire cmd_t                  cmd,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  output rsp_t                       rsp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                 accept;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ELEM_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [ELEM_BITS-1:0] mem_rdata;
  status_t              status;

  assign accept = cmd_valid && cmd_ready;

  rfow_ctrl #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .status    (status)
  );

  rfow_mem #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rfow_out #(
    .ELEM_BITS (ELEM_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .status    (status),
    .rdata     (mem_rdata),
    .can_take  (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// File: design/rfow_checker.sv
// Port-level assertions for the ring FIFO top level and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module rfow_checker import rfow_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("Stalled response changed or dropped.");

  a_fill_below_mark: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.fill_count <= rsp.high_water)
    else $error("Fill count exceeds the high-water mark.");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.pop_valid |-> rsp.pop_value == '0)
    else $error("Pop value is nonzero without a popped element.");

  a_overflow_no_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.overflow_status != OVF_NONE |-> !rsp.pop_valid)
    else $error("Overflow reported together with a popped element.");

endmodule

bind ring_fifo_overwrite_watermark_unit rfow_checker u_rfow_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the ring FIFO with overwrite mode and high-water mark.
`timescale 1ns / 1ps

module tb_top;
  import rfow_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 65;
  localparam int DIR_ROWS    = 24;

  typedef struct {
    op_t                op;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    logic               pv;
    logic [VALUE_W-1:0] pval;
    ovf_t               ovf;
    logic [COUNT_W-1:0] fill;
    logic [COUNT_W-1:0] hw;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cmd_valid;
  logic                  cmd_ready;
  cmd_t                  cmd;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_t                  rsp;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit quiet = 1'b0;
  int mismatches = 0;
  int cycle_cnt = 0;

  logic               mdl_overwrite = 1'b0;
  logic [CFG_LEN_W-1:0] mdl_length  = CFG_LEN_RESET;
  logic [VALUE_W-1:0] mdl_slots [DEPTH];
  logic [3:0]         mdl_rd = '0;
  logic [3:0]         mdl_wr = '0;
  logic [COUNT_W-1:0] mdl_held = '0;
  logic [COUNT_W-1:0] mdl_peak = '0;

  rsp_t pending_rsp [$];
  dir_row_t dir_tbl [DIR_ROWS];

  ring_fifo_overwrite_watermark_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] next_slot(input logic [3:0] idx, input logic [4:0] len);
    logic [4:0] n;
    n = {1'b0, idx} + 5'd1;
    return (n >= len) ? 4'd0 : n[3:0];
  endfunction

  function automatic void fifo_predict(input cmd_t c, output rsp_t r);
    logic [4:0] len;
    bit         take;
    len  = (mdl_length == 0) ? 5'd1 : (mdl_length > DEPTH) ? 5'(DEPTH) : mdl_length;
    take = 1'b1;
    r    = '0;
    r.overflow_status = OVF_NONE;
    case (c.op)
      OP_PUSH: begin
        if (mdl_held >= len) begin
          if (mdl_overwrite) begin
            mdl_rd = next_slot(mdl_rd, len);
            mdl_held = mdl_held - 5'd1;
            r.overflow_status = OVF_DROP;
          end else begin
            take = 1'b0;
            r.overflow_status = OVF_REJECT;
          end
        end
        if (take) begin
          mdl_slots[mdl_wr] = c.push_value;
          mdl_wr = next_slot(mdl_wr, len);
          mdl_held = mdl_held + 5'd1;
          if (mdl_held > mdl_peak) mdl_peak = mdl_held;
        end
      end
      OP_POP: begin
        if (mdl_held != 0) begin
          r.pop_valid = 1'b1;
          r.pop_value = mdl_slots[mdl_rd];
          mdl_rd = next_slot(mdl_rd, len);
          mdl_held = mdl_held - 5'd1;
        end
      end
      OP_CLEAR: begin
        mdl_held = '0;
        mdl_rd = '0;
        mdl_wr = '0;
      end
      default: begin
      end
    endcase
    r.fill_count = mdl_held;
    r.high_water = mdl_peak;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_cmd(input cmd_t c, input bit typed, input rsp_t typed_rsp);
    rsp_t model_rsp;
    while (!quiet && $urandom_range(0, 99) < 15) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    fifo_predict(c, model_rsp);
    pending_rsp.push_back(typed ? typed_rsp : model_rsp);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic write_config(input logic ow, input logic [CFG_LEN_W-1:0] len);
    cfg_we <= 1'b1;
    cfg_index <= REG_OVERWRITE;
    cfg_data <= {4'($urandom_range(0, 15)), ow};
    mdl_overwrite = ow;
    @(negedge clk);
    cfg_index <= REG_LENGTH;
    cfg_data <= len;
    mdl_length = len;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    rsp_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual %p", $time, rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.pop_valid !== want.pop_valid || rsp.pop_value !== want.pop_value ||
            rsp.overflow_status !== want.overflow_status ||
            rsp.fill_count !== want.fill_count || rsp.high_water !== want.high_water) begin
          mismatches++;
          $display("%0t: mismatch, expected pop_valid=%0d pop_value=%h ovf=%0d fill=%0d hw=%0d",
                   $time, want.pop_valid, want.pop_value, want.overflow_status,
                   want.fill_count, want.high_water);
          $display("%0t:           actual pop_valid=%0d pop_value=%h ovf=%0d fill=%0d hw=%0d",
                   $time, rsp.pop_valid, rsp.pop_value, rsp.overflow_status,
                   rsp.fill_count, rsp.high_water);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[ring_fifo_overwrite_watermark_unit] ERROR");
      $finish;
    end
  end

  initial begin
    logic                 ph_ow [PHASES];
    logic [CFG_LEN_W-1:0] ph_len [PHASES];
    cmd_t                 c;
    rsp_t                 t;
    int                   burst_left;
    bit                   push_heavy;
    int                   roll;

    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    rsp_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    // Reset state, then sixteen pushes so that every slot holds a known value.
    dir_tbl = '{
      '{OP_POP,   32'h0000_0000, 1, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_NOP,   32'hFFFF_FFFF, 1, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_CLEAR, 32'hFFFF_FFFF, 1, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'h0000_0000, 1, 1'b0, 32'h0000_0000, OVF_NONE,   5'd1,  5'd1},
      '{OP_PUSH,  32'hFFFF_FFFF, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'hAAAA_AAAA, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'h5555_5555, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'h8000_0000, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'h0000_0001, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'h7FFF_FFFF, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'hFFFF_FFFE, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'h0F0F_0F0F, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'hF0F0_F0F0, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'h1234_5678, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'h9ABC_DEF0, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'h00FF_00FF, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'hFF00_FF00, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'h3C3C_3C3C, 0, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd0},
      '{OP_PUSH,  32'hC3C3_C3C3, 1, 1'b0, 32'h0000_0000, OVF_NONE,   5'd16, 5'd16},
      '{OP_PUSH,  32'hDEAD_0000, 1, 1'b0, 32'h0000_0000, OVF_REJECT, 5'd16, 5'd16},
      '{OP_POP,   32'h0000_0000, 1, 1'b1, 32'h0000_0000, OVF_NONE,   5'd15, 5'd16},
      '{OP_POP,   32'h0000_0000, 1, 1'b1, 32'hFFFF_FFFF, OVF_NONE,   5'd14, 5'd16},
      '{OP_CLEAR, 32'h0000_0000, 1, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd16},
      '{OP_POP,   32'h0000_0000, 1, 1'b0, 32'h0000_0000, OVF_NONE,   5'd0,  5'd16}
    };

    ph_ow  = '{1'b1,  1'b0, 1'b1, 1'b1, 1'b0,  1'b1,  1'b0, 1'b1, 1'b0,  1'b1};
    ph_len = '{5'd16, 5'd1, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd3, 5'd16, 5'd16};
    ph_ow[PHASES-1]  = 1'($urandom_range(0, 1));
    ph_len[PHASES-1] = 5'($urandom_range(0, 31));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      c.op = dir_tbl[i].op;
      c.push_value = dir_tbl[i].value;
      t.pop_valid = dir_tbl[i].pv;
      t.pop_value = dir_tbl[i].pval;
      t.overflow_status = dir_tbl[i].ovf;
      t.fill_count = dir_tbl[i].fill;
      t.high_water = dir_tbl[i].hw;
      send_cmd(c, dir_tbl[i].typed, t);
    end

    t = '0;
    burst_left = 0;
    push_heavy = 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      cmd_valid <= 1'b0;
      drain_results();
      quiet = (p == 4 || p == 5);
      write_config(ph_ow[p], ph_len[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          push_heavy = 1'($urandom_range(0, 1));
          burst_left = $urandom_range(6, 24);
        end
        burst_left--;
        roll = $urandom_range(0, 99);
        if (roll < 4) c.op = OP_CLEAR;
        else if (roll < 8) c.op = OP_NOP;
        else if (roll < (push_heavy ? 74 : 30)) c.op = OP_PUSH;
        else c.op = OP_POP;
        roll = $urandom_range(0, 9);
        c.push_value = (roll == 0) ? 32'h0000_0000 :
                       (roll == 1) ? 32'hFFFF_FFFF : 32'($urandom);
        send_cmd(c, 1'b0, t);
      end
    end

    cmd_valid <= 1'b0;
    quiet = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ring_fifo_overwrite_watermark_unit] OK");
    end else begin
      $display("[ring_fifo_overwrite_watermark_unit] ERROR");
    end
    $finish;
  end

endmodule
